### rtl/skvt_pkg.sv
package skvt_pkg;

   // Default table depth
   localparam int CAPACITY_DEF = 16;

   // Field widths
   localparam int KEY_W    = 64;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;
   localparam int POS_W    = 5;
   localparam int REQ_DATA_W = KEY_W + VALUE_W;
   localparam int RSP_DATA_W = 48;

   // Request kinds (carried on req_tuser)
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_UPDATED   = 3'd1,
      ST_FOUND     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   // Write strobes broadcast to every cell
   typedef struct packed {
      logic insert_en;
      logic update_en;
   } cell_ctrl_type;

endpackage

### rtl/skvt_cell.sv
// One table slot: holds a key/value pair, compares against the broadcast key
// and takes either the new entry or its left neighbor's entry on an insert.
module skvt_cell
   import skvt_pkg::*;
#(
   parameter int INDEX   = 0,
   parameter int INDEX_W = 5
) (
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic [INDEX_W-1:0]  count,
   input  logic [KEY_W-1:0]    op_key,
   input  logic [VALUE_W-1:0]  op_value,
   input  logic                left_lt,
   input  logic [KEY_W-1:0]    left_key,
   input  logic [VALUE_W-1:0]  left_value,
   output logic                lt,
   output logic                eq,
   output logic [KEY_W-1:0]    key,
   output logic [VALUE_W-1:0]  value
);

   logic [KEY_W-1:0]   key_ff;
   logic [KEY_W-1:0]   key_in;
   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;
   logic               occupied;
   logic               take_new;
   logic               take_left;

   // Slot holds a live entry when it sits below the fill count
   assign occupied = count > INDEX_W'(INDEX);
   assign lt       = occupied && (key_ff < op_key);
   assign eq       = occupied && (key_ff == op_key);

   // Insert boundary takes the new entry, everything above it shifts up
   assign take_new  = ctrl.insert_en && !lt && left_lt;
   assign take_left = ctrl.insert_en && !lt && !left_lt;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (take_new) begin
         key_in   = op_key;
         value_in = op_value;
      end else if (take_left) begin
         key_in   = left_key;
         value_in = left_value;
      end else if (ctrl.update_en && eq) begin
         value_in = op_value;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign key   = key_ff;
   assign value = value_ff;

endmodule

### rtl/sorted_key_value_table.sv
// Sorted key/value table built as a row of CAPACITY slots kept in ascending
// unsigned key order. The accept latches the request into the request
// registers; when the item completes, every slot compares its key against the
// request in parallel, the position and any match are resolved, the result
// is registered and, on an insert, the whole row shifts up past the insertion
// point in that same clock. A new item is accepted while a result still waits
// on rsp_tready; the request completes once the result register is free.
// No clearing pass follows reset: the fill count alone marks live slots.
module sorted_key_value_table
   import skvt_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // key[63:0], value[95:64]
   input  logic                  req_tuser,   // kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // found[0], result_value[32:1],
                                              // position[37:33], count[42:38]
   output logic [STATUS_W-1:0]   rsp_tuser    // status
);

   localparam int IDX_W  = $clog2(CAPACITY + 1);
   localparam int WIDE_W = (IDX_W > POS_W) ? IDX_W : POS_W;

   // Request and control registers
   logic                  busy_ff, busy_in;
   logic                  op_kind_ff;
   logic [KEY_W-1:0]      op_key_ff;
   logic [VALUE_W-1:0]    op_value_ff;
   logic [IDX_W-1:0]      count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;

   logic accept;
   logic complete;

   // Cell row signals
   logic                lt_vec   [CAPACITY];
   logic                eq_vec   [CAPACITY];
   logic [KEY_W-1:0]    key_vec  [CAPACITY];
   logic [VALUE_W-1:0]  val_vec  [CAPACITY];
   cell_ctrl_type       ctrl;

   // Resolved search results
   logic                hit;
   logic [VALUE_W-1:0]  hit_value;
   logic [IDX_W-1:0]    pos;
   logic                full;
   status_type          status;
   logic [VALUE_W-1:0]  res_value;
   logic [WIDE_W-1:0]   pos_wide;
   logic [WIDE_W-1:0]   count_wide;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   assign accept     = req_tvalid && req_tready;
   assign complete   = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !busy_ff;

   // Slot row
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic               left_lt;
      logic [KEY_W-1:0]   left_key;
      logic [VALUE_W-1:0] left_value;
      if (g == 0) begin : g_first
         assign left_lt    = 1'b1;
         assign left_key   = op_key_ff;
         assign left_value = op_value_ff;
      end else begin : g_rest
         assign left_lt    = lt_vec[g-1];
         assign left_key   = key_vec[g-1];
         assign left_value = val_vec[g-1];
      end
      skvt_cell #(
         .INDEX   (g),
         .INDEX_W (IDX_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count_ff),
         .op_key     (op_key_ff),
         .op_value   (op_value_ff),
         .left_lt    (left_lt),
         .left_key   (left_key),
         .left_value (left_value),
         .lt         (lt_vec[g]),
         .eq         (eq_vec[g]),
         .key        (key_vec[g]),
         .value      (val_vec[g])
      );
   end

   // Match, value and insertion point from the row's compare flags
   always_comb begin
      hit       = 1'b0;
      hit_value = '0;
      pos       = lt_vec[CAPACITY-1] ? IDX_W'(CAPACITY) : '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit       = hit | eq_vec[i];
         hit_value = hit_value | (eq_vec[i] ? val_vec[i] : '0);
         if (!lt_vec[i] && (i == 0 || lt_vec[(i == 0) ? 0 : i-1])) begin
            pos = pos | IDX_W'(i);
         end
      end
   end

   assign full = count_ff == IDX_W'(CAPACITY);

   // Operation decode
   always_comb begin
      ctrl      = '0;
      status    = ST_NOT_FOUND;
      res_value = '0;
      count_in  = count_ff;
      if (op_kind_ff == KIND_LOOKUP) begin
         if (hit) begin
            status    = ST_FOUND;
            res_value = hit_value;
         end
      end else if (hit) begin
         status         = ST_UPDATED;
         ctrl.update_en = complete;
      end else if (full) begin
         status = ST_FULL;
      end else begin
         status         = ST_INSERTED;
         ctrl.insert_en = complete;
         count_in       = count_ff + IDX_W'(1);
      end
   end

   assign pos_wide   = WIDE_W'(pos);
   assign count_wide = WIDE_W'(count_in);
   assign rsp_data_in = RSP_DATA_W'({count_wide[POS_W-1:0], pos_wide[POS_W-1:0],
                                     res_value, hit});

   assign busy_in      = accept ? 1'b1 : (complete ? 1'b0 : busy_ff);
   assign rsp_valid_in = complete ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (complete) begin
            count_ff <= count_in;
         end
      end
   end

   // Request latch
   always_ff @(posedge clock) begin
      if (accept) begin
         op_kind_ff  <= req_tuser;
         op_key_ff   <= req_tdata[KEY_W-1:0];
         op_value_ff <= req_tdata[KEY_W +: VALUE_W];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (complete) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule
